// File: rtl/bgauge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgauge_pkg
// Shared widths, constants, types and sequencer states of the battery gauge.
// ----------------------------------------------------------------------------
package bgauge_pkg;

  // burst length default and upper bound
  localparam int SPR_DEF = 8;
  localparam int SPR_MAX = 64;

  // field widths
  localparam int RAW_W  = 12;
  localparam int SUM_W  = 18;   // 64 * 4095 fits
  localparam int CNT_W  = 7;    // holds 0..64
  localparam int MV_W   = 13;
  localparam int PCT_W  = 7;
  localparam int REM_W  = 23;
  localparam int THR_W  = 13;
  localparam int CAP_W  = 16;
  localparam int IDLE_W = 12;
  localparam int C_W    = 11;   // clamped span 0..1200

  // configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IDLE_CURRENT  = 2'd2;
  localparam int IDLE_RESET = 80;

  // shared divider
  localparam int DIV_W     = 27;  // capacity * span fits
  localparam int DVS_W     = 16;  // 12 * idle current fits
  localparam int DIV_CNT_W = 5;

  // products
  localparam int PIN_PROD_W = 24;

  // scaling constants
  localparam int PIN_SCALE    = 3300;
  localparam int ADC_FULL     = 4095;
  localparam int MV_EMPTY     = 3000;
  localparam int MV_SPAN      = 1200;
  localparam int PCT_SCALE    = 100;
  localparam int PCT_ROUND    = 600;
  localparam int REM_DIV_MULT = 12;
  localparam int MV_MAX       = 6600;
  localparam int PCT_MAX      = 100;

  // 4095 = 2^12 - 1: x / 4095 = (y + (y >> 12)) >> 12 with y = x + 1
  localparam int ADC_SHIFT    = $clog2(ADC_FULL + 1);
  // (c*100 + 600) / 1200 = (c + 6) / 12, exact as * 683 >> 13 below 2048
  localparam int PCT_BIAS     = PCT_ROUND / PCT_SCALE;
  localparam int PCT_RECIP    = 683;
  localparam int PCT_RECIP_SH = 13;
  localparam int PCT_PROD_W   = 20;

  // burst queue
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } burst_t;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [CAP_W-1:0]  capacity;
    logic [IDLE_W-1:0] idle;
  } cfg_t;

  typedef struct packed {
    logic             ok;
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    logic             low;
    logic [REM_W-1:0] rem;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG_GO,
    S_AVG_W,
    S_PIN,
    S_CLAMP,
    S_PCT,
    S_REM_MUL,
    S_REM_GO,
    S_REM_W,
    S_DONE
  } back_state_t;

endpackage

// File: rtl/bgauge_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgauge_front
// Burst accumulator: sums and counts good samples, hands each finished burst
// to the queue.
// ----------------------------------------------------------------------------
module bgauge_front #(
  parameter int SAMPLES_PER_READING = bgauge_pkg::SPR_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [bgauge_pkg::RAW_W-1:0]  sample_raw,
  input  logic                          sample_ok,
  output logic                          burst_push,
  output bgauge_pkg::burst_t            burst
);

  localparam int IDX_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;

  logic [bgauge_pkg::SUM_W-1:0] sum;
  logic [bgauge_pkg::CNT_W-1:0] count;
  logic [IDX_W-1:0]             index;
  logic [bgauge_pkg::SUM_W-1:0] sum_next;
  logic [bgauge_pkg::CNT_W-1:0] count_next;
  logic                         last;

  assign sum_next   = sample_ok ? sum + bgauge_pkg::SUM_W'(sample_raw) : sum;
  assign count_next = sample_ok ? count + bgauge_pkg::CNT_W'(1) : count;
  assign last       = (index == IDX_W'(SAMPLES_PER_READING - 1));

  assign burst_push  = accept && last;
  assign burst.sum   = sum_next;
  assign burst.count = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      index <= '0;
    end else if (accept) begin
      if (last) begin
        sum   <= '0;
        count <= '0;
        index <= '0;
      end else begin
        sum   <= sum_next;
        count <= count_next;
        index <= index + IDX_W'(1);
      end
    end
  end

endmodule

// File: rtl/bgauge_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgauge_queue
// Short register queue of finished bursts between front and back.
// ----------------------------------------------------------------------------
module bgauge_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bgauge_pkg::burst_t wdata,
  output logic               full,
  output logic               valid,
  input  logic               pop,
  output bgauge_pkg::burst_t rdata
);

  localparam int PTR_W = (bgauge_pkg::QUEUE_DEPTH > 1) ? $clog2(bgauge_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(bgauge_pkg::QUEUE_DEPTH + 1);

  bgauge_pkg::burst_t entries [bgauge_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == FILL_W'(bgauge_pkg::QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(bgauge_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(bgauge_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// File: rtl/bgauge_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgauge_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgauge_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bgauge_pkg::DIV_W-1:0] dividend,
  input  logic [bgauge_pkg::DVS_W-1:0] divisor,
  output logic                         busy,
  output logic                         done,
  output logic [bgauge_pkg::DIV_W-1:0] quotient
);

  logic [bgauge_pkg::DIV_W-1:0]     quo;
  logic [bgauge_pkg::DVS_W-1:0]     rem;
  logic [bgauge_pkg::DVS_W-1:0]     dvs;
  logic [bgauge_pkg::DIV_CNT_W-1:0] cnt;
  logic [bgauge_pkg::DVS_W:0]       trial;
  logic [bgauge_pkg::DVS_W:0]       diff;
  logic                             ge;

  // shift in next dividend bit, subtract when it fits
  assign trial    = {rem, quo[bgauge_pkg::DIV_W-1]};
  assign ge       = (trial >= {1'b0, dvs});
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[bgauge_pkg::DIV_W-2:0], ge};
      rem <= ge ? diff[bgauge_pkg::DVS_W-1:0] : trial[bgauge_pkg::DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= bgauge_pkg::DIV_CNT_W'(bgauge_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - bgauge_pkg::DIV_CNT_W'(1);
        if (cnt == bgauge_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/bgauge_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgauge_back
// Reading sequencer: turns one burst into a reading through the shared
// divider and holds it in the result register.
// ----------------------------------------------------------------------------
module bgauge_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bgauge_pkg::cfg_t     cfg,
  input  logic                 q_valid,
  input  bgauge_pkg::burst_t   q_data,
  output logic                 q_pop,
  input  logic                 res_pop,
  output logic                 res_valid,
  output bgauge_pkg::result_t  res
);

  bgauge_pkg::back_state_t state;
  bgauge_pkg::back_state_t state_next;

  bgauge_pkg::burst_t                   burst;
  logic [bgauge_pkg::DIV_W-1:0]         prod;
  logic [bgauge_pkg::MV_W-1:0]          mv;
  logic [bgauge_pkg::C_W-1:0]           span;
  logic [bgauge_pkg::PCT_W-1:0]         pct;
  logic                                 low;
  logic [bgauge_pkg::REM_W-1:0]         rem;

  logic                                 div_start;
  logic [bgauge_pkg::DIV_W-1:0]         div_dividend;
  logic [bgauge_pkg::DVS_W-1:0]         div_divisor;
  logic                                 div_busy;
  logic                                 div_done;
  logic [bgauge_pkg::DIV_W-1:0]         div_quo;
  logic                                 load_out;

  logic [bgauge_pkg::PIN_PROD_W-1:0]    pin_prod;
  logic [bgauge_pkg::PIN_PROD_W-1:0]    pin_inc;
  logic [bgauge_pkg::PIN_PROD_W-1:0]    pin_fold;
  logic [bgauge_pkg::DIV_W-1:0]         rem_prod;
  logic [bgauge_pkg::C_W-1:0]           pct_sum;
  logic [bgauge_pkg::PCT_PROD_W-1:0]    pct_prod;
  logic [bgauge_pkg::DVS_W-1:0]         rem_dvs;
  logic [bgauge_pkg::MV_W-1:0]          over;
  logic [bgauge_pkg::C_W-1:0]           span_next;
  logic                                 est_on;
  logic                                 out_ok;

  bgauge_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign pin_prod = bgauge_pkg::PIN_PROD_W'(div_quo[bgauge_pkg::RAW_W-1:0])
                  * bgauge_pkg::PIN_PROD_W'(bgauge_pkg::PIN_SCALE);
  // divide by 4095 with a fold of the upper bits
  assign pin_inc  = prod[bgauge_pkg::PIN_PROD_W-1:0] + bgauge_pkg::PIN_PROD_W'(1);
  assign pin_fold = pin_inc + (pin_inc >> bgauge_pkg::ADC_SHIFT);
  assign rem_prod = bgauge_pkg::DIV_W'(cfg.capacity) * bgauge_pkg::DIV_W'(span);
  // rounded percent by reciprocal multiplication
  assign pct_sum  = span + bgauge_pkg::C_W'(bgauge_pkg::PCT_BIAS);
  assign pct_prod = bgauge_pkg::PCT_PROD_W'(pct_sum)
                  * bgauge_pkg::PCT_PROD_W'(bgauge_pkg::PCT_RECIP);
  assign rem_dvs  = bgauge_pkg::DVS_W'(cfg.idle) * bgauge_pkg::DVS_W'(bgauge_pkg::REM_DIV_MULT);
  assign est_on   = (cfg.capacity != '0) && (cfg.idle != '0);
  assign out_ok   = (mv != '0);

  // clamp mv - 3000 into 0..1200
  assign over = mv - bgauge_pkg::MV_W'(bgauge_pkg::MV_EMPTY);
  always_comb begin
    if (mv <= bgauge_pkg::MV_W'(bgauge_pkg::MV_EMPTY)) begin
      span_next = '0;
    end else if (over > bgauge_pkg::MV_W'(bgauge_pkg::MV_SPAN)) begin
      span_next = bgauge_pkg::C_W'(bgauge_pkg::MV_SPAN);
    end else begin
      span_next = over[bgauge_pkg::C_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bgauge_pkg::S_IDLE: begin
        if (q_valid) begin
          state_next = (q_data.count == '0) ? bgauge_pkg::S_DONE : bgauge_pkg::S_AVG_GO;
        end
      end
      bgauge_pkg::S_AVG_GO:  state_next = bgauge_pkg::S_AVG_W;
      bgauge_pkg::S_AVG_W:   if (div_done) state_next = bgauge_pkg::S_PIN;
      bgauge_pkg::S_PIN:     state_next = bgauge_pkg::S_CLAMP;
      bgauge_pkg::S_CLAMP: begin
        state_next = (mv == '0) ? bgauge_pkg::S_DONE : bgauge_pkg::S_PCT;
      end
      bgauge_pkg::S_PCT: begin
        state_next = est_on ? bgauge_pkg::S_REM_MUL : bgauge_pkg::S_DONE;
      end
      bgauge_pkg::S_REM_MUL: state_next = bgauge_pkg::S_REM_GO;
      bgauge_pkg::S_REM_GO:  state_next = bgauge_pkg::S_REM_W;
      bgauge_pkg::S_REM_W:   if (div_done) state_next = bgauge_pkg::S_DONE;
      bgauge_pkg::S_DONE:    if (!res_valid || res_pop) state_next = bgauge_pkg::S_IDLE;
      default:               state_next = bgauge_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    q_pop        = 1'b0;
    load_out     = 1'b0;
    case (state)
      bgauge_pkg::S_IDLE: q_pop = q_valid;
      bgauge_pkg::S_AVG_GO: begin
        div_start    = 1'b1;
        div_dividend = bgauge_pkg::DIV_W'(burst.sum);
        div_divisor  = bgauge_pkg::DVS_W'(burst.count);
      end
      bgauge_pkg::S_REM_GO: begin
        div_start    = 1'b1;
        div_dividend = prod;
        div_divisor  = rem_dvs;
      end
      bgauge_pkg::S_DONE: load_out = !res_valid || res_pop;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bgauge_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      bgauge_pkg::S_IDLE: begin
        burst <= q_data;
        mv    <= '0;
      end
      bgauge_pkg::S_AVG_W: if (div_done) prod <= bgauge_pkg::DIV_W'(pin_prod);
      bgauge_pkg::S_PIN: begin
        mv <= {pin_fold[bgauge_pkg::PIN_PROD_W-1:bgauge_pkg::ADC_SHIFT], 1'b0};
      end
      bgauge_pkg::S_CLAMP: begin
        span <= span_next;
        low  <= (cfg.threshold != '0) && (mv < cfg.threshold);
      end
      bgauge_pkg::S_PCT: begin
        pct <= pct_prod[bgauge_pkg::PCT_RECIP_SH +: bgauge_pkg::PCT_W];
        rem <= '0;
      end
      bgauge_pkg::S_REM_MUL: prod <= rem_prod;
      bgauge_pkg::S_REM_W: if (div_done) rem <= div_quo[bgauge_pkg::REM_W-1:0];
      default: ;
    endcase
  end

  // result register, zeroed fields on an invalid reading
  always_ff @(posedge clk) begin
    if (load_out) begin
      res.ok  <= out_ok;
      res.mv  <= mv;
      res.pct <= out_ok ? pct : '0;
      res.low <= out_ok && low;
      res.rem <= out_ok ? rem : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("burst queue popped while empty");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_mv_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.mv <= bgauge_pkg::MV_W'(bgauge_pkg::MV_MAX))
    else $error("battery voltage out of range");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.pct <= bgauge_pkg::PCT_W'(bgauge_pkg::PCT_MAX))
    else $error("percent out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.ok) |-> (res.mv == '0 && res.rem == '0 && !res.low))
    else $error("invalid reading carries nonzero fields");

endmodule

// File: rtl/battery_gauge_from_adc_burst.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_gauge_from_adc_burst
// Averages bursts of converter samples into battery voltage, percent, low flag
// and remaining runtime.
// ----------------------------------------------------------------------------
// usage:
//   samples enter as a queue write: a transfer happens when push is high and
//   full is low. while full is low one sample is taken every cycle; every
//   SAMPLES_PER_READING-th sample closes a burst and yields one reading.
//   readings leave as a queue read: the oldest reading sits on the result
//   ports while empty is low, and pop with empty low completes the transfer.
//   with the result register free, empty falls once the back has turned a
//   finished burst into a reading: the average and, with the runtime
//   estimate on, the runtime estimate run in one shared bit-serial
//   divider, the constant scalings take a state each, and a burst with no
//   good sample or a voltage of zero skips the steps that follow. the back
//   takes one burst at a time; a two-entry burst queue lets the front take
//   samples while the back works. a stalled receiver holds the reading in
//   the result register; the back then waits, the burst queue fills, and
//   full rises. registers are written through cfg_write/cfg_index/cfg_data;
//   the user must write them only while the block is idle, which the block
//   does not enforce. unknown indexes are ignored. synchronous reset empties
//   the queues, clears the accumulators, sets threshold 0, capacity 0, 80 mA.
// ----------------------------------------------------------------------------
module battery_gauge_from_adc_burst #(
  parameter int SAMPLES_PER_READING = bgauge_pkg::SPR_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [bgauge_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bgauge_pkg::CFG_DATA_W-1:0]  cfg_data,
  // sample input
  input  logic                               push,
  output logic                               full,
  input  logic [bgauge_pkg::RAW_W-1:0]       sample_raw,
  input  logic                               sample_ok,
  // reading output
  output logic                               empty,
  input  logic                               pop,
  output logic                               reading_valid,
  output logic [bgauge_pkg::MV_W-1:0]        battery_mv,
  output logic [bgauge_pkg::PCT_W-1:0]       battery_percent,
  output logic                               battery_low,
  output logic [bgauge_pkg::REM_W-1:0]       remaining_centihours
);

  bgauge_pkg::cfg_t    cfg;
  bgauge_pkg::burst_t  burst_in;
  bgauge_pkg::burst_t  burst_out;
  bgauge_pkg::result_t res;
  logic                in_accept;
  logic                burst_push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  logic                res_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= '0;
      cfg.capacity  <= '0;
      cfg.idle      <= bgauge_pkg::IDLE_W'(bgauge_pkg::IDLE_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        bgauge_pkg::CFG_IDX_LOW_THRESHOLD: cfg.threshold <= cfg_data[bgauge_pkg::THR_W-1:0];
        bgauge_pkg::CFG_IDX_CAPACITY:      cfg.capacity  <= cfg_data[bgauge_pkg::CAP_W-1:0];
        bgauge_pkg::CFG_IDX_IDLE_CURRENT:  cfg.idle      <= cfg_data[bgauge_pkg::IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  // the front stalls whenever the burst queue has no room
  assign full      = q_full;
  assign in_accept = push && !q_full;

  bgauge_front #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .sample_raw (sample_raw),
    .sample_ok  (sample_ok),
    .burst_push (burst_push),
    .burst      (burst_in)
  );

  bgauge_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (burst_push),
    .wdata (burst_in),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (burst_out)
  );

  bgauge_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (burst_out),
    .q_pop     (q_pop),
    .res_pop   (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  // result ports straight from the back's result register
  assign empty                = !res_valid;
  assign reading_valid        = res.ok;
  assign battery_mv           = res.mv;
  assign battery_percent      = res.pct;
  assign battery_low          = res.low;
  assign remaining_centihours = res.rem;

endmodule
